// ===== rtl/core/ftps_pkg.sv =====
// Shared constants, types and functions for the frame time statistics core.
// No dependencies; used by every module under rtl/core except ftps_div.
`default_nettype none

package ftps_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int MAX_FRAMES_DEF  = 1024;
    localparam int VALUE_BITS_DEF  = 24;
    localparam int NUM_METRICS_DEF = 9;

    // Fixed field widths of the streams.
    localparam int FIELD_W   = 24;
    localparam int STAT_W    = 24;
    localparam int INDEX_W   = 5;
    localparam int ALL_LANES = 9;
    localparam int SUBSYS    = 8;
    localparam int PCT_W     = 7;
    localparam int FRAC_W    = 16;

    localparam logic [FIELD_W-1:0] HITCH_THR_RESET = 24'd34133;
    localparam logic [14:0]        PERCENT_SCALE   = 15'd25600;
    localparam logic [PCT_W-1:0]   PCT_DIVISOR     = 7'd100;

    // Reciprocal of 100: (x * RECIP_100) >> RECIP_SHIFT equals x / 100 for any 32-bit x.
    localparam logic [31:0] RECIP_100   = 32'h51EB851F;
    localparam int          RECIP_SHIFT = 37;

    // Statistic codes on the result stream.
    localparam logic [INDEX_W-1:0] STAT_TOTAL   = 5'd0;
    localparam logic [INDEX_W-1:0] STAT_P50     = 5'd1;
    localparam logic [INDEX_W-1:0] STAT_P90     = 5'd2;
    localparam logic [INDEX_W-1:0] STAT_P95     = 5'd3;
    localparam logic [INDEX_W-1:0] STAT_P99     = 5'd4;
    localparam logic [INDEX_W-1:0] STAT_MIN     = 5'd5;
    localparam logic [INDEX_W-1:0] STAT_MAX     = 5'd6;
    localparam logic [INDEX_W-1:0] STAT_MEAN    = 5'd7;
    localparam logic [INDEX_W-1:0] STAT_HITCHES = 5'd8;
    localparam logic [INDEX_W-1:0] STAT_PERCENT = 5'd9;
    localparam logic [INDEX_W-1:0] STAT_SS_BASE = 5'd10;
    localparam logic [INDEX_W-1:0] STAT_LAST    = 5'd17;

    // Jobs run after the end of a trace: four ranks, then mean and percentage.
    localparam logic [2:0] DIV_RANK_LAST = 3'd3;
    localparam logic [2:0] DIV_MEAN      = 3'd4;
    localparam logic [2:0] DIV_PERCENT   = 3'd5;

    // Rank index of the p95 job, shared by the subsystem lanes.
    localparam int RANK_P95 = 2;

    // Control handed along the row of cells.
    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctrl_t;

    // Percent of each rank job: p50, p90, p95, p99.
    function automatic logic [PCT_W-1:0] rank_pct(input logic [1:0] idx);
        logic [PCT_W-1:0] p;
        unique case (idx)
            2'd0:    p = 7'd50;
            2'd1:    p = 7'd90;
            2'd2:    p = 7'd95;
            default: p = 7'd99;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/frame_time_percentile_stats_core.sv =====
// Top level of the frame time statistics core: stream ports, counters, control.
// Depends on ftps_pkg, ftps_chain (with ftps_cell) and ftps_div.
//
//  channel  | direction | tdata                              | tuser     | tlast
//  s_*      | in        | nine 24-bit metrics, duration low  | has_frame | last
//  m_*      | out       | stat_index[4:0], stat_value[28:5]  | overflow  | last_result
//  cfg_*    | in        | hitch threshold, 24 bits           | -         | -
//
// A frame item is accepted while idle; if it carries a frame and the rows are not full,
// every row of cells inserts it in that cycle. After an item with tlast, four rank
// jobs run in turn on a reciprocal multiplier, then mean and percentage run on the
// shared divider, then the rows shift out, then 18 results follow, each held
// through any output stall. An empty trace skips straight to the results.
// s_tready is low throughout that run.
// Reset empties the stores by clearing the fill count; no clearing pass is needed.
`default_nettype none

module frame_time_percentile_stats_core #(
    parameter int MAX_FRAMES  = ftps_pkg::MAX_FRAMES_DEF,
    parameter int VALUE_BITS  = ftps_pkg::VALUE_BITS_DEF,
    parameter int NUM_METRICS = ftps_pkg::NUM_METRICS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // Configuration: hitch threshold.
    input  wire logic          cfg_wr_en,
    input  wire logic [23:0]   cfg_wr_data,
    // Input: tdata from bit 0: frame_duration, game_thread_time, render_thread_time,
    // rhi_thread_time, gpu_time, physics_time, ai_time, network_time, loading_time.
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [215:0]  s_tdata,
    input  wire logic          s_tuser,   // has_frame
    input  wire logic          s_tlast,   // last
    // Output: tdata from bit 0: stat_index[4:0], stat_value[28:5], zero pad.
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tuser,   // overflow
    output logic               m_tlast    // last_result
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = VALUE_BITS + CNT_W;
    localparam int PCTQ_W = CNT_W + 15;
    localparam int DIV_W  = (SUM_W > PCTQ_W) ? SUM_W : PCTQ_W;
    localparam int DVS_W  = CNT_W;
    localparam int FW     = ftps_pkg::FIELD_W;
    localparam int YW     = CNT_W + ftps_pkg::PCT_W;
    localparam int QPW    = YW + 32;
    localparam int FPW    = ftps_pkg::FRAC_W + ftps_pkg::PCT_W + 32;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DSTART = 6'b000010,
        S_DWAIT  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_LOAD   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      n_reg, n_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      hitch_reg, hitch_next;
    logic                  drop_reg, drop_next;
    logic [FW-1:0]         thr_reg;
    logic [2:0]            sel_reg, sel_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [4:0]            out_k_reg, out_k_next;

    logic [CNT_W-1:0]          lo_reg [4];
    logic [15:0]               f_reg  [4];
    logic [23:0]               mean_reg;
    logic [23:0]               pct_reg;
    logic [VALUE_BITS-1:0]     dlo_reg [4];
    logic [VALUE_BITS-1:0]     dhi_reg [4];
    logic [VALUE_BITS-1:0]     slo_reg [ftps_pkg::SUBSYS];
    logic [VALUE_BITS-1:0]     shi_reg [ftps_pkg::SUBSYS];
    logic [VALUE_BITS-1:0]     min_reg;
    logic [VALUE_BITS-1:0]     max_reg;

    logic                  m_valid_reg;
    logic [31:0]           m_data_reg;
    logic                  m_user_reg;
    logic                  m_last_reg;

    logic                  s_acc;
    logic                  m_acc;
    logic                  do_ins;
    ftps_pkg::cell_ctrl_t  ctrl;
    logic [VALUE_BITS-1:0] in_vals  [ftps_pkg::ALL_LANES];
    logic [VALUE_BITS-1:0] head_all [ftps_pkg::ALL_LANES];

    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic [DIV_W-1:0]      div_quot;

    logic [YW-1:0]                 rank_y_reg;
    logic [YW-1:0]                 rank_q_reg;
    logic [ftps_pkg::PCT_W-1:0]    rank_rem_reg;
    logic [1:0]                    rank_step_reg;
    logic [QPW-1:0]                rank_q_prod;
    logic [FPW-1:0]                rank_f_prod;
    logic [ftps_pkg::FRAC_W-1:0]   rank_frac;
    logic                          is_rank;
    logic                          rank_done;
    logic                          job_done;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_valid_reg && m_tready;
    assign do_ins   = s_acc && s_tuser && (n_reg < CNT_W'(MAX_FRAMES));

    assign ctrl.ins   = do_ins;
    assign ctrl.shift = (state_reg == S_SCAN);

    // Input fields cut to the store width.
    for (genvar g = 0; g < ftps_pkg::ALL_LANES; g++) begin : g_in
        assign in_vals[g] = VALUE_BITS'(s_tdata[g*FW +: FW]);
    end

    // One sorted row per metric; metrics without a row read as zero.
    for (genvar g = 0; g < ftps_pkg::ALL_LANES; g++) begin : g_lane
        if (g < NUM_METRICS) begin : g_row
            ftps_chain #(
                .MAX_FRAMES (MAX_FRAMES),
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W)
            ) u_chain (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .new_value (in_vals[g]),
                .count     (n_reg),
                .head      (head_all[g])
            );
        end else begin : g_none
            assign head_all[g] = '0;
        end
    end

    // Rank jobs: y = (n - 1) * pct is split as 100 * q + rem, so the rank index is q
    // and the 16-bit fraction is rem * 65536 / 100, both by reciprocal multiplication.
    assign is_rank     = (sel_reg <= ftps_pkg::DIV_RANK_LAST);
    assign rank_q_prod = QPW'(rank_y_reg) * QPW'(ftps_pkg::RECIP_100);
    assign rank_f_prod = FPW'({rank_rem_reg, 16'b0}) * FPW'(ftps_pkg::RECIP_100);
    assign rank_frac   = ftps_pkg::FRAC_W'(rank_f_prod >> ftps_pkg::RECIP_SHIFT);
    assign rank_done   = (rank_step_reg == 2'd2);
    assign job_done    = is_rank ? rank_done : div_done;

    // Registered stages in order: operand, quotient, remainder; the fraction follows.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DSTART) begin
            rank_y_reg    <= YW'(n_reg - 1'b1) * YW'(ftps_pkg::rank_pct(sel_reg[1:0]));
            rank_step_reg <= '0;
        end else if (state_reg == S_DWAIT) begin
            rank_step_reg <= rank_step_reg + 1'b1;
        end
        rank_q_reg   <= YW'(rank_q_prod >> ftps_pkg::RECIP_SHIFT);
        rank_rem_reg <= ftps_pkg::PCT_W'(rank_y_reg
                        - rank_q_reg * YW'(ftps_pkg::PCT_DIVISOR));
    end

    // Operands of the current division job.
    always_comb begin
        div_dividend = DIV_W'(sum_reg);
        div_divisor  = DVS_W'(n_reg);
        if (sel_reg == ftps_pkg::DIV_PERCENT) begin
            div_dividend = DIV_W'(PCTQ_W'(hitch_reg) * PCTQ_W'(ftps_pkg::PERCENT_SCALE));
        end
    end

    assign div_start = (state_reg == S_DSTART) && !is_rank;

    ftps_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer and trace counters.
    always_comb begin
        logic [31:0] dur;
        dur        = 32'(in_vals[0]);
        state_next = state_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        hitch_next = hitch_reg;
        drop_next  = drop_reg;
        sel_next   = sel_reg;
        k_next     = k_reg;
        out_k_next = out_k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (do_ins) begin
                        n_next   = n_reg + 1'b1;
                        sum_next = sum_reg + SUM_W'(in_vals[0]);
                        if (dur > 32'(thr_reg)) begin
                            hitch_next = hitch_reg + 1'b1;
                        end
                    end else if (s_tuser) begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast) begin
                        sel_next   = '0;
                        k_next     = '0;
                        out_k_next = '0;
                        state_next = (n_next == '0) ? S_LOAD : S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (job_done) begin
                    if (sel_reg == ftps_pkg::DIV_PERCENT) begin
                        state_next = S_SCAN;
                    end else begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_SCAN: begin
                k_next = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_acc) begin
                    if (out_k_reg == ftps_pkg::STAT_LAST) begin
                        n_next     = '0;
                        sum_next   = '0;
                        hitch_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        out_k_next = out_k_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            sum_reg   <= '0;
            hitch_reg <= '0;
            drop_reg  <= 1'b0;
            thr_reg   <= ftps_pkg::HITCH_THR_RESET;
            sel_reg   <= '0;
            k_reg     <= '0;
            out_k_reg <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            sum_reg   <= sum_next;
            hitch_reg <= hitch_next;
            drop_reg  <= drop_next;
            sel_reg   <= sel_next;
            k_reg     <= k_next;
            out_k_reg <= out_k_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // Job results: ranks split into index and fraction, then mean and percent.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DWAIT && job_done) begin
            if (is_rank) begin
                lo_reg[sel_reg[1:0]] <= CNT_W'(rank_q_reg);
                f_reg[sel_reg[1:0]]  <= rank_frac;
            end else if (sel_reg == ftps_pkg::DIV_MEAN) begin
                mean_reg <= 24'(div_quot);
            end else begin
                pct_reg <= 24'(div_quot);
            end
        end
    end

    // Catch the neighbouring ranks as the rows shift past cell 0.
    always_ff @(posedge aclk) begin
        if (state_reg == S_SCAN) begin
            for (int j = 0; j < 4; j++) begin
                if (k_reg == lo_reg[j]) begin
                    dlo_reg[j] <= head_all[0];
                end
                if ((CNT_W + 1)'(k_reg) == (CNT_W + 1)'(lo_reg[j]) + 1'b1) begin
                    dhi_reg[j] <= head_all[0];
                end
            end
            for (int m = 0; m < ftps_pkg::SUBSYS; m++) begin
                if (k_reg == lo_reg[ftps_pkg::RANK_P95]) begin
                    slo_reg[m] <= head_all[m+1];
                end
                if ((CNT_W + 1)'(k_reg)
                        == (CNT_W + 1)'(lo_reg[ftps_pkg::RANK_P95]) + 1'b1) begin
                    shi_reg[m] <= head_all[m+1];
                end
            end
            if (k_reg == '0) begin
                min_reg <= head_all[0];
            end
            if (k_reg == n_reg - 1'b1) begin
                max_reg <= head_all[0];
            end
        end
    end

    // Result value: interpolation through one shared multiplier, or a plain pick.
    logic [VALUE_BITS-1:0]    ip_lo, ip_hi;
    logic [15:0]              ip_f;
    logic [VALUE_BITS+15:0]   ip_prod;
    logic [VALUE_BITS-1:0]    ip_val;
    logic [23:0]              stat_val;
    logic [2:0]               ss_idx;

    assign ss_idx = 3'(out_k_reg - ftps_pkg::STAT_SS_BASE);

    always_comb begin
        ip_lo = slo_reg[ss_idx];
        ip_hi = shi_reg[ss_idx];
        ip_f  = f_reg[ftps_pkg::RANK_P95];
        priority if (out_k_reg == ftps_pkg::STAT_P50) begin
            ip_lo = dlo_reg[0]; ip_hi = dhi_reg[0]; ip_f = f_reg[0];
        end else if (out_k_reg == ftps_pkg::STAT_P90) begin
            ip_lo = dlo_reg[1]; ip_hi = dhi_reg[1]; ip_f = f_reg[1];
        end else if (out_k_reg == ftps_pkg::STAT_P95) begin
            ip_lo = dlo_reg[2]; ip_hi = dhi_reg[2]; ip_f = f_reg[2];
        end else if (out_k_reg == ftps_pkg::STAT_P99) begin
            ip_lo = dlo_reg[3]; ip_hi = dhi_reg[3]; ip_f = f_reg[3];
        end else begin
            ip_f = f_reg[ftps_pkg::RANK_P95];
        end
    end

    assign ip_prod = (VALUE_BITS + 16)'(ip_hi - ip_lo) * (VALUE_BITS + 16)'(ip_f);
    assign ip_val  = ip_lo + VALUE_BITS'(ip_prod >> ftps_pkg::FRAC_W);

    always_comb begin
        unique case (out_k_reg)
            ftps_pkg::STAT_TOTAL:   stat_val = 24'(n_reg);
            ftps_pkg::STAT_P50,
            ftps_pkg::STAT_P90,
            ftps_pkg::STAT_P95,
            ftps_pkg::STAT_P99:     stat_val = 24'(ip_val);
            ftps_pkg::STAT_MIN:     stat_val = 24'(min_reg);
            ftps_pkg::STAT_MAX:     stat_val = 24'(max_reg);
            ftps_pkg::STAT_MEAN:    stat_val = mean_reg;
            ftps_pkg::STAT_HITCHES: stat_val = 24'(hitch_reg);
            ftps_pkg::STAT_PERCENT: stat_val = pct_reg;
            default: begin
                stat_val = (32'(ss_idx) + 1 < NUM_METRICS) ? 24'(ip_val) : 24'd0;
            end
        endcase
        if (n_reg == '0) begin
            stat_val = '0;
        end
    end

    // Output register: loaded once per result, held until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_LOAD) begin
            m_valid_reg <= 1'b1;
        end else if (m_acc) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == S_LOAD) begin
            m_data_reg <= {3'b000, stat_val, out_k_reg};
            m_user_reg <= drop_reg;
            m_last_reg <= (out_k_reg == ftps_pkg::STAT_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // The result register is only full while the sequencer waits on it.
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == S_OUT))
        else $error("result held outside output state");

    // The fill count never passes the row length.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above capacity");

    // The final result of a run empties the trace counters.
    a_run_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_last_reg) |=> (n_reg == '0 && hitch_reg == '0 && !drop_reg))
        else $error("trace counters not cleared after final result");

    // Only results up to the last code are ever sequenced.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_k_reg <= ftps_pkg::STAT_LAST)
        else $error("result index out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ftps_cell.sv =====
// One cell of a sorted insertion row: holds one value of one metric.
// Depends on ftps_pkg for the cell control struct.
`default_nettype none

module ftps_cell #(
    parameter int VALUE_BITS = ftps_pkg::VALUE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire ftps_pkg::cell_ctrl_t   ctrl,
    input  wire logic [VALUE_BITS-1:0]  new_value,
    input  wire logic [VALUE_BITS-1:0]  left_value,
    input  wire logic                   left_gt,
    input  wire logic [VALUE_BITS-1:0]  right_value,
    input  wire logic                   occupied,
    input  wire logic                   at_end,
    output logic [VALUE_BITS-1:0]       value,
    output logic                        gt
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    // An occupied cell above the new value makes room for it.
    assign gt = occupied && (value_reg > new_value);

    // Insertion takes the left neighbour when it is also larger, else the new value.
    always_comb begin
        value_next = value_reg;
        if (ctrl.shift) begin
            value_next = right_value;
        end else if (ctrl.ins && (gt || at_end)) begin
            value_next = left_gt ? left_value : new_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ftps_chain.sv =====
// Row of cells keeping one metric sorted ascending; shifts out towards cell 0.
// Depends on ftps_pkg and ftps_cell.
`default_nettype none

module ftps_chain #(
    parameter int MAX_FRAMES = ftps_pkg::MAX_FRAMES_DEF,
    parameter int VALUE_BITS = ftps_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
    input  wire logic                   aclk,
    input  wire ftps_pkg::cell_ctrl_t   ctrl,
    input  wire logic [VALUE_BITS-1:0]  new_value,
    input  wire logic [CNT_W-1:0]       count,
    output logic [VALUE_BITS-1:0]       head
);

    logic [VALUE_BITS-1:0] vals [MAX_FRAMES];
    logic                  gts  [MAX_FRAMES];

    // Each cell sees its neighbours and its own place against the fill count.
    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        logic [VALUE_BITS-1:0] left_v;
        logic                  left_g;
        logic [VALUE_BITS-1:0] right_v;

        if (i == 0) begin : g_first
            assign left_v = '0;
            assign left_g = 1'b0;
        end else begin : g_inner
            assign left_v = vals[i-1];
            assign left_g = gts[i-1];
        end

        if (i == MAX_FRAMES - 1) begin : g_tail
            assign right_v = vals[i];
        end else begin : g_body
            assign right_v = vals[i+1];
        end

        ftps_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_value  (left_v),
            .left_gt     (left_g),
            .right_value (right_v),
            .occupied    (CNT_W'(i) < count),
            .at_end      (CNT_W'(i) == count),
            .value       (vals[i]),
            .gt          (gts[i])
        );
    end

    assign head = vals[0];

endmodule

`default_nettype wire

// ===== rtl/core/ftps_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the mean and the percentage.
// Depends on nothing but its parameters.
`default_nettype none

module ftps_div #(
    parameter int DIV_W = 48,
    parameter int DVS_W = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  acc_reg, acc_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, acc_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            acc_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
            acc_next  = {acc_reg[DIV_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

`default_nettype wire
